[hdl/mmfs_pkg.sv]
// ---------------------------------------------------------------------------
// mmfs_pkg
// Shared widths, operation codes and statistic reset values of the min-max
// feature scaler.
// ---------------------------------------------------------------------------
package mmfs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FEAT_W   = 6;
	localparam int OP_W     = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [SAMPLE_W-1:0]        span_t;

	localparam logic [OP_W-1:0] OP_OBSERVE   = 2'd0;
	localparam logic [OP_W-1:0] OP_NORMALIZE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

	localparam sample_t STAT_MIN_INIT = 16'sh7FFF;
	localparam sample_t STAT_MAX_INIT = 16'sh8000;

endpackage

[hdl/mmfs_div.sv]
// ---------------------------------------------------------------------------
// mmfs_div
// Restoring divider, one quotient bit per cycle: quo = (num << FRAC_BITS) / den
// for num <= den, den > 0.
// ---------------------------------------------------------------------------
module mmfs_div
	import mmfs_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  span_t              num,
	input  span_t              den,
	output logic               done,
	output logic [FRAC_BITS:0] quo
);

	localparam int CW = $clog2(FRAC_BITS + 1);

	logic                 active_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [SAMPLE_W:0]    rem_q;
	span_t                den_q;
	logic [FRAC_BITS:0]   quo_q;

	logic                 ge;
	logic [SAMPLE_W:0]    diff;
	logic [SAMPLE_W:0]    rem_next;

	assign ge       = rem_q >= {1'b0, den_q};
	assign diff     = rem_q - {1'b0, den_q};
	assign rem_next = ge ? {diff[SAMPLE_W-1:0], 1'b0} : {rem_q[SAMPLE_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (cnt_q == CW'(FRAC_BITS)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (active_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/min_max_feature_scaler.sv]
// ---------------------------------------------------------------------------
// min_max_feature_scaler
// Per-feature min/max statistics in one synchronous RAM; normalize words
// return (sample - min) / (max - min) with FRAC_BITS fraction bits.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------
//   command  | start / busy     | op, feature, sample
//   result   | done (one cycle) | scaled, clamped, flat
//
// Observe: RAM read, then read-modify-write.
// Normalize: RAM read, then evaluation; flat or clamped results come from the
// evaluation step, all others from the one-bit-per-cycle divider.
// Clear, and reset: a sweep rewrites every RAM entry in turn; busy stays
// high throughout.
// Results cannot be stalled; done marks each result for one cycle.
// ---------------------------------------------------------------------------
module min_max_feature_scaler
	import mmfs_pkg::*;
#(
	parameter int FEATURES  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    op,
	input  logic [FEAT_W-1:0]  feature,
	input  sample_t            sample,
	output logic               done,
	output logic [FRAC_BITS:0] scaled,
	output logic               clamped,
	output logic               flat
);

	localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLEAR = 4'b0010,
		S_EVAL  = 4'b0100,
		S_DIV   = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	logic [OP_W-1:0]        op_q;
	logic                   in_range_q;
	logic [AW-1:0]          addr_q;
	sample_t                sample_q;
	logic [2*SAMPLE_W-1:0]  rd_q;
	logic [2*SAMPLE_W-1:0]  mem [FEATURES];

	logic                   done_q;
	logic [FRAC_BITS:0]     scaled_q;
	logic                   clamped_q;
	logic                   flat_q;

	logic [AW+FEAT_W-1:0]   feat_ext;
	logic [AW-1:0]          feat_addr;
	logic                   feat_ok;
	logic                   accept;

	sample_t                lo, hi, new_min, new_max;
	logic signed [SAMPLE_W:0] num_d, den_d;
	logic                   is_flat, below, above;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [2*SAMPLE_W-1:0]  mem_wdata;
	logic                   div_load;
	logic                   div_done;
	logic [FRAC_BITS:0]     div_quo;

	assign feat_ext  = {{AW{1'b0}}, feature};
	assign feat_addr = feat_ext[AW-1:0];
	assign feat_ok   = feat_ext < (AW+FEAT_W)'(FEATURES);
	assign accept    = start && (state_q == S_IDLE);

	assign lo      = in_range_q ? sample_t'(rd_q[2*SAMPLE_W-1:SAMPLE_W]) : STAT_MIN_INIT;
	assign hi      = in_range_q ? sample_t'(rd_q[SAMPLE_W-1:0]) : STAT_MAX_INIT;
	assign new_min = (sample_q < lo) ? sample_q : lo;
	assign new_max = (sample_q > hi) ? sample_q : hi;
	assign is_flat = hi <= lo;
	assign below   = sample_q < lo;
	assign above   = sample_q > hi;
	assign num_d   = (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(lo);
	assign den_d   = (SAMPLE_W+1)'(hi) - (SAMPLE_W+1)'(lo);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {new_min, new_max};
		div_load  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {STAT_MIN_INIT, STAT_MAX_INIT};
			end
			S_EVAL: begin
				mem_we   = (op_q == OP_OBSERVE) && in_range_q;
				div_load = (op_q == OP_NORMALIZE) && !is_flat && !below && !above;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[feat_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op;
			in_range_q <= feat_ok;
			addr_q     <= feat_addr;
			sample_q   <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (op == OP_CLEAR) begin
							state_q <= S_CLEAR;
							clr_q   <= '0;
						end else if (op == OP_OBSERVE || op == OP_NORMALIZE) begin
							state_q <= S_EVAL;
						end
					end
				end
				S_CLEAR: begin
					if (clr_q == AW'(FEATURES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_EVAL: begin
					if (div_load) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_IDLE;
						done_q  <= (op_q == OP_NORMALIZE);
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			flat_q    <= is_flat;
			clamped_q <= !is_flat && (below || above);
			scaled_q  <= (!is_flat && !below && above) ? {1'b1, {FRAC_BITS{1'b0}}} : '0;
		end else if (state_q == S_DIV && div_done) begin
			flat_q    <= 1'b0;
			clamped_q <= 1'b0;
			scaled_q  <= div_quo;
		end
	end

	mmfs_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (div_load),
		.num   (num_d[SAMPLE_W-1:0]),
		.den   (den_d[SAMPLE_W-1:0]),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign scaled  = scaled_q;
	assign clamped = clamped_q;
	assign flat    = flat_q;

endmodule

[bench/min_max_feature_scaler_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// min_max_feature_scaler_tb
// Self-checking bench for the min-max feature scaler. A clocked driver feeds
// command words from a queue and keeps a shadow copy of the per-feature
// statistics, from which it predicts each normalize result. A clocked monitor
// compares every done strobe against the oldest prediction. Directed corner
// words come first, then random observe/normalize streams over a small set of
// features with clears, unused codes and a few sender idle phases.
// ---------------------------------------------------------------------------
module min_max_feature_scaler_tb;
	import mmfs_pkg::*;

	localparam int FEATURES  = 64;
	localparam int FRAC_BITS = 16;
	localparam int N_RANDOM  = 1300;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [FEAT_W-1:0] feature;
		sample_t           sample;
		bit                hold;
	} cmd_word_t;

	typedef struct packed {
		logic [FRAC_BITS:0] scaled;
		logic               clamped;
		logic               flat;
	} scale_t;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic [OP_W-1:0]    op      = '0;
	logic [FEAT_W-1:0]  feature = '0;
	sample_t            sample  = '0;
	logic               busy;
	logic               done;
	logic [FRAC_BITS:0] scaled;
	logic               clamped;
	logic               flat;

	cmd_word_t pending[$];
	scale_t    expected_scale[$];
	cmd_word_t next_word;
	sample_t   stat_min[FEATURES];
	sample_t   stat_max[FEATURES];
	int        words_sent = 0;
	int        total_words = 0;
	int        errors = 0;

	min_max_feature_scaler #(
		.FEATURES(FEATURES),
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.feature(feature),
		.sample(sample),
		.done(done),
		.scaled(scaled),
		.clamped(clamped),
		.flat(flat)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (errors < 40) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
		errors++;
	endtask

	task automatic clear_stats();
		for (int i = 0; i < FEATURES; i++) begin
			stat_min[i] = STAT_MIN_INIT;
			stat_max[i] = STAT_MAX_INIT;
		end
	endtask

	function automatic scale_t normalize_word(input sample_t s, input logic [FEAT_W-1:0] f);
		scale_t r;
		int     lo;
		int     hi;
		int     v;
		longint num;
		longint den;
		r  = '0;
		lo = int'(stat_min[f]);
		hi = int'(stat_max[f]);
		v  = int'(s);
		if (hi <= lo) begin
			r.flat = 1'b1;
		end else if (v < lo) begin
			r.clamped = 1'b1;
		end else if (v > hi) begin
			r.clamped = 1'b1;
			r.scaled  = (FRAC_BITS+1)'(1) << FRAC_BITS;
		end else begin
			num = longint'(v - lo);
			den = longint'(hi - lo);
			r.scaled = (FRAC_BITS+1)'((num << FRAC_BITS) / den);
		end
		return r;
	endfunction

	task automatic predict_word(input logic [OP_W-1:0] o, input logic [FEAT_W-1:0] f,
			input sample_t s);
		case (o)
			OP_OBSERVE: begin
				if (s < stat_min[f]) stat_min[f] = s;
				if (s > stat_max[f]) stat_max[f] = s;
			end
			OP_NORMALIZE: expected_scale = {expected_scale, normalize_word(s, f)};
			OP_CLEAR: clear_stats();
			default: ;
		endcase
	endtask

	// sender idle percentage per phase: none, idle, receiver-only (no effect), both
	function automatic int idle_pct();
		case ((words_sent / 200) % 4)
			1: return 55;
			3: return 26;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_word(op, feature, sample);
				words_sent <= words_sent + 1;
			end
			if (!start || !busy) begin
				if (pending.size() != 0 && $urandom_range(99) >= idle_pct() &&
						!(pending[0].hold && expected_scale.size() != 0)) begin
					next_word = pending.pop_front();
					start   <= 1'b1;
					op      <= next_word.op;
					feature <= next_word.feature;
					sample  <= next_word.sample;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		scale_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (expected_scale.size() == 0) begin
					report_mismatch("result with no normalize word outstanding");
				end else begin
					want = expected_scale.pop_front();
					if (scaled !== want.scaled)
						report_mismatch($sformatf("scaled %0d, expected %0d",
							scaled, want.scaled));
					if (clamped !== want.clamped)
						report_mismatch($sformatf("clamped %b, expected %b",
							clamped, want.clamped));
					if (flat !== want.flat)
						report_mismatch($sformatf("flat %b, expected %b",
							flat, want.flat));
				end
			end else if (done !== 1'b0) begin
				report_mismatch("done unknown");
			end
		end
	end

	task automatic add_word(input logic [OP_W-1:0] o, input int f, input int s,
			input bit h = 1'b0);
		cmd_word_t w;
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		w.op      = o;
		w.feature = f[FEAT_W-1:0];
		w.sample  = sample_t'(s);
		w.hold    = h;
		pending = {pending, w};
		total_words++;
	endtask

	function automatic int pick_spread();
		case ($urandom_range(4))
			0: return 0;
			1: return 1;
			2: return $urandom_range(15);
			3: return $urandom_range(1000);
			default: return $urandom_range(32767);
		endcase
	endfunction

	initial begin
		int center[8];
		int spread[8];
		int r;
		int f;
		int s;
		int reach;
		logic [OP_W-1:0] o;

		clear_stats();

		add_word(OP_NORMALIZE, 0, 0);
		add_word(OP_OBSERVE, 63, -32768);
		add_word(OP_NORMALIZE, 63, -32768);
		add_word(OP_OBSERVE, 63, 32767);
		add_word(OP_NORMALIZE, 63, -32768);
		add_word(OP_NORMALIZE, 63, 32767);
		add_word(OP_NORMALIZE, 63, 0);
		add_word(OP_NORMALIZE, 63, -1);
		add_word(OP_OBSERVE, 1, -100);
		add_word(OP_OBSERVE, 1, 100);
		add_word(OP_NORMALIZE, 1, -101);
		add_word(OP_NORMALIZE, 1, 101);
		add_word(OP_NORMALIZE, 1, -100);
		add_word(OP_NORMALIZE, 1, 100);
		add_word(OP_NORMALIZE, 1, 99);
		add_word(OP_UNUSED, 1, 21845);
		add_word(OP_NORMALIZE, 1, 0, 1'b1);
		add_word(OP_CLEAR, 0, 0);
		add_word(OP_NORMALIZE, 63, 0);
		add_word(OP_NORMALIZE, 1, 0);
		add_word(OP_OBSERVE, 2, 5);
		add_word(OP_OBSERVE, 2, 5);
		add_word(OP_NORMALIZE, 2, 5);

		for (int i = 0; i < 8; i++) begin
			center[i] = int'($urandom_range(65535)) - 32768;
			spread[i] = pick_spread();
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			r = $urandom_range(99);
			if (r < 2) begin
				add_word(OP_CLEAR, $urandom_range(63), int'(sample_t'($urandom)));
				for (int k = 0; k < 8; k++) begin
					center[k] = int'($urandom_range(65535)) - 32768;
					spread[k] = pick_spread();
				end
			end else if (r < 5) begin
				add_word(OP_UNUSED, $urandom_range(63), int'(sample_t'($urandom)));
			end else begin
				f = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7);
				o = (r < 52) ? OP_OBSERVE : OP_NORMALIZE;
				if ($urandom_range(9) == 0) begin
					s = int'(sample_t'($urandom));
				end else begin
					reach = spread[f % 8];
					if (o == OP_NORMALIZE && $urandom_range(7) == 0)
						reach = reach * 2 + 1;
					s = center[f % 8] + int'($urandom_range(2 * reach)) - reach;
				end
				add_word(o, f, s, i == N_RANDOM / 2);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (words_sent != total_words || expected_scale.size() != 0)
			@(negedge clk);
		repeat (FEATURES + FRAC_BITS + 20) @(negedge clk);

		if (expected_scale.size() != 0)
			report_mismatch("normalize results still outstanding at end");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
hdl/mmfs_pkg.sv
hdl/mmfs_div.sv
hdl/min_max_feature_scaler.sv
bench/min_max_feature_scaler_tb.sv
